// File: hdl/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg: shared definitions for the ordered list engine
// Command and status codes, the per-cell operation code and the control
// bundle that the top level broadcasts to every cell.
// ----------------------------------------------------------------------------
package olist_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int WIDTH_DEFAULT = 32;

    // Fixed field widths of the stream payload.
    localparam int CMD_W   = 3;
    localparam int POS_W   = 6;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    // What each cell does with its stored word when a command fires.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_FILL,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN
    } cell_op_t;

    typedef struct packed {
        logic     fire;
        cell_op_t op;
        logic     rd_en;
        logic     find_en;
    } cell_ctrl_t;

endpackage

// File: hdl/olist_cell.sv
// ----------------------------------------------------------------------------
// olist_cell: one entry of the ordered list
// Holds a single word, trades it with its neighbors on shifts and captures
// its read value and find match when a command fires.
// ----------------------------------------------------------------------------
module olist_cell #(
    parameter int DEPTH = olist_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = olist_pkg::WIDTH_DEFAULT,
    parameter int INDEX = 0
) (
    input  logic                    clk,
    input  olist_pkg::cell_ctrl_t   ctrl,
    input  logic [($clog2(DEPTH+1) > olist_pkg::POS_W ?
                   $clog2(DEPTH+1) : olist_pkg::POS_W) : 0] pos,
    input  logic [($clog2(DEPTH+1) > olist_pkg::POS_W ?
                   $clog2(DEPTH+1) : olist_pkg::POS_W) : 0] count,
    input  logic [($clog2(DEPTH+1) > olist_pkg::POS_W ?
                   $clog2(DEPTH+1) : olist_pkg::POS_W) : 0] target,
    input  logic [WIDTH-1:0]        key,
    input  logic [WIDTH-1:0]        left_entry,
    input  logic [WIDTH-1:0]        right_entry,
    output logic [WIDTH-1:0]        entry,
    output logic [WIDTH-1:0]        cap,
    output logic                    hit
);
    import olist_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W ? CNT_W : POS_W) + 1;
    localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

    logic [WIDTH-1:0] entry_reg;
    logic [WIDTH-1:0] cap_reg;
    logic             hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.fire)
        begin
            unique case (ctrl.op)
                CELL_PUSH:
                begin
                    if (IDX == count)
                        entry_reg <= key;
                end
                CELL_FILL:
                begin
                    if (IDX == pos)
                        entry_reg <= key;
                    else if (IDX >= count && IDX < pos)
                        entry_reg <= '0;
                end
                CELL_SHIFT_UP:
                begin
                    if (IDX == pos)
                        entry_reg <= key;
                    else if (IDX > pos && IDX <= count)
                        entry_reg <= left_entry;
                end
                CELL_SHIFT_DOWN:
                begin
                    if (IDX >= pos && IDX + 1'b1 < count)
                        entry_reg <= right_entry;
                end
                default:
                begin
                    entry_reg <= entry_reg;
                end
            endcase
            // Captures use the contents from before this command.
            cap_reg <= (ctrl.rd_en && IDX == target) ? entry_reg : '0;
            hit_reg <= ctrl.find_en && (IDX < count) && (entry_reg == key);
        end
    end

    assign entry = entry_reg;
    assign cap   = cap_reg;
    assign hit   = hit_reg;

endmodule

// File: hdl/olist_collect.sv
// ----------------------------------------------------------------------------
// olist_collect: result gathering across the cell row
// Merges the captured read words and picks the lowest matching cell.
// ----------------------------------------------------------------------------
module olist_collect #(
    parameter int DEPTH = olist_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = olist_pkg::WIDTH_DEFAULT
) (
    input  logic [DEPTH-1:0][WIDTH-1:0] caps,
    input  logic [DEPTH-1:0]            hits,
    output logic [WIDTH-1:0]            value,
    output logic                        hit_any,
    output logic [$clog2(DEPTH)-1:0]    hit_index
);
    import olist_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic [DEPTH-1:0] first_hit;

    // Isolate the lowest set bit of the match vector.
    assign first_hit = hits & (~hits + {{(DEPTH-1){1'b0}}, 1'b1});
    assign hit_any   = |hits;

    always_comb
    begin
        value     = '0;
        hit_index = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            value = value | caps[i];
            if (first_hit[i])
                hit_index = hit_index | IDX_W'(i);
        end
    end

endmodule

// File: hdl/ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_top: bounded ordered list with push, pop, insert,
// remove, find, read and clear
// A row of entry cells with a shared result collector and stream ports.
// ----------------------------------------------------------------------------
// At the accepting edge every cell applies the shift or write for that
// command and latches its own read word and find match from the old
// contents; once the output register is free, the collector merges those
// captures and the result is loaded into the output register. A new command
// is accepted in the cycle after the result is loaded, even if the previous
// result has not yet been taken; the block takes no new command before the
// result of the last one is loaded. The entry words have no reset: a cell
// is only read below the count, and every such cell has been written.
// Command code seven is ignored and answers with status ok. Results come
// back in command order, one per command.
// ----------------------------------------------------------------------------
module ordered_list_engine_top #(
    parameter int DEPTH = olist_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = olist_pkg::WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata, from bit 0 up: command[3], position[6], value_in[32], zero pad.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    // m_tdata, from bit 0 up: status[2], value_out[32], found_index[6],
    // count_out[clog2(DEPTH+1)], zero pad to whole bytes.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((40 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);
    import olist_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W ? CNT_W : POS_W) + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int OUT_W = ((40 + CNT_W + 7) / 8) * 8;
    localparam int PAD_W = OUT_W - 40 - CNT_W;

    // Input fields.
    logic [CMD_W-1:0]   command;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value_in;

    assign command  = s_tdata[2:0];
    assign position = s_tdata[8:3];
    assign value_in = s_tdata[40:9];

    // Control state.
    logic             busy_reg,      busy_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] count_reg,     count_next;

    // Result of the decision made at acceptance, held for the collector edge.
    logic [STAT_W-1:0] pend_status_reg;
    logic              pend_find_reg;
    logic [CNT_W-1:0]  pend_count_reg;

    // Output register payload.
    logic [STAT_W-1:0]  status_reg;
    logic [VALUE_W-1:0] value_out_reg;
    logic [POS_W-1:0]   found_index_reg;
    logic [CNT_W-1:0]   count_out_reg;

    logic accept;
    logic load_out;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign load_out = busy_reg && (!out_valid_reg || m_tready);

    // Command decode against the current count.
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic [CMP_W-1:0]  ins_count;
    logic [CMP_W-1:0]  target;
    logic [WIDTH-1:0]  key;
    logic [STAT_W-1:0] status_dec;
    cell_ctrl_t        ctrl;

    assign pos_x     = CMP_W'(position);
    assign cnt_x     = CMP_W'(count_reg);
    assign ins_count = ((pos_x >= cnt_x) ? pos_x : cnt_x) + 1'b1;
    assign key       = WIDTH'(value_in);

    always_comb
    begin
        ctrl.fire    = accept;
        ctrl.op      = CELL_HOLD;
        ctrl.rd_en   = 1'b0;
        ctrl.find_en = 1'b0;
        target       = pos_x;
        status_dec   = ST_OK;
        count_next   = count_reg;
        unique case (command)
            CMD_PUSH:
            begin
                if (cnt_x == CMP_W'(DEPTH))
                    status_dec = ST_FULL;
                else
                begin
                    ctrl.op    = CELL_PUSH;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_POP:
            begin
                if (count_reg == '0)
                    status_dec = ST_EMPTY;
                else
                begin
                    ctrl.rd_en = 1'b1;
                    target     = cnt_x - 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_INSERT:
            begin
                if (ins_count > CMP_W'(DEPTH))
                    status_dec = ST_FULL;
                else
                begin
                    ctrl.op    = (pos_x >= cnt_x) ? CELL_FILL : CELL_SHIFT_UP;
                    count_next = CNT_W'(ins_count);
                end
            end
            CMD_REMOVE:
            begin
                if (pos_x >= cnt_x)
                    status_dec = ST_MISS;
                else
                begin
                    ctrl.op    = CELL_SHIFT_DOWN;
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_FIND:
            begin
                ctrl.find_en = 1'b1;
            end
            CMD_READ:
            begin
                if (pos_x >= cnt_x)
                    status_dec = ST_MISS;
                else
                    ctrl.rd_en = 1'b1;
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                // Unused code: no change, status ok.
                count_next = count_reg;
            end
        endcase
    end

    // The row of entry cells.
    logic [DEPTH-1:0][WIDTH-1:0] entries;
    logic [DEPTH-1:0][WIDTH-1:0] caps;
    logic [DEPTH-1:0]            hits;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [WIDTH-1:0] left_entry;
        logic [WIDTH-1:0] right_entry;

        if (g == 0)
        begin : g_first
            assign left_entry = '0;
        end
        else
        begin : g_mid_l
            assign left_entry = entries[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_mid_r
            assign right_entry = entries[g+1];
        end

        olist_cell #(
            .DEPTH (DEPTH),
            .WIDTH (WIDTH),
            .INDEX (g)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .pos         (pos_x),
            .count       (cnt_x),
            .target      (target),
            .key         (key),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[g]),
            .cap         (caps[g]),
            .hit         (hits[g])
        );
    end

    // Result collection over the captured cell outputs.
    logic [WIDTH-1:0] coll_value;
    logic             coll_hit;
    logic [IDX_W-1:0] coll_index;

    olist_collect #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_collect (
        .caps      (caps),
        .hits      (hits),
        .value     (coll_value),
        .hit_any   (coll_hit),
        .hit_index (coll_index)
    );

    // Control registers.
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (load_out)
            busy_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    // Payload registers: pending decision and the output transaction. The
    // output fields change only when a new result is loaded, so a result that
    // waits for the receiver stays intact while the next command is taken.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= status_dec;
            pend_find_reg   <= ctrl.find_en;
            pend_count_reg  <= count_next;
        end
        if (load_out)
        begin
            value_out_reg <= VALUE_W'(coll_value);
            count_out_reg <= pend_count_reg;
            if (pend_find_reg)
            begin
                status_reg      <= coll_hit ? ST_OK : ST_MISS;
                found_index_reg <= coll_hit ? POS_W'(coll_index) : '0;
            end
            else
            begin
                status_reg      <= pend_status_reg;
                found_index_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, count_out_reg, found_index_reg,
                       value_out_reg, status_reg};

    // The count never passes the capacity.
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    // A command in flight reaches the output register or waits for it.
    a_busy_drains : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> (busy_reg || m_tvalid))
        else $error("command left the collector without a result");

    // A pop on a non-empty list takes exactly one entry off.
    a_pop_count : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_POP && count_reg != '0)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not decrement the count");

endmodule

// File: bench/tb_ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_top: self-checking bench for the ordered list engine
// Drives list commands into the stream input, mirrors the list contents in a
// scoreboard that predicts every result, and compares each result transaction
// field by field while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine_top;

    import olist_pkg::*;

    localparam int DEPTH      = DEPTH_DEFAULT;
    localparam int WIDTH      = WIDTH_DEFAULT;
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int M_W        = ((40 + COUNT_W + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;

    // Code seven has no name in the package; the block ignores it.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    // One expected result transaction, in the block's field widths.
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VALUE_W-1:0] value_out;
        logic [POS_W-1:0]   found_index;
        logic [COUNT_W-1:0] count_out;
    } list_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the list, works out the result of each
    // accepted command and matches result transactions against them in order.
    // ------------------------------------------------------------------------
    class list_scoreboard;
        logic [WIDTH-1:0] entries [DEPTH];
        int               entry_count;
        list_result_t     expected_results [$];
        int               error_count;

        function new();
            entry_count = 0;
            error_count = 0;
            foreach (entries[i])
                entries[i] = '0;
        endfunction

        // Applies one accepted command to the mirrored list and queues the
        // result that the block must answer with.
        function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                   logic [VALUE_W-1:0] val);
            list_result_t res;
            int           p;
            int           grown;
            bit           hit;
            res = '0;
            p   = int'(pos);
            hit = 1'b0;
            case (cmd)
                CMD_PUSH:
                    if (entry_count >= DEPTH)
                        res.status = ST_FULL;
                    else
                    begin
                        entries[entry_count] = val[WIDTH-1:0];
                        entry_count++;
                    end
                CMD_POP:
                    if (entry_count == 0)
                        res.status = ST_EMPTY;
                    else
                    begin
                        entry_count--;
                        res.value_out = VALUE_W'(entries[entry_count]);
                    end
                CMD_INSERT:
                begin
                    grown = ((p >= entry_count) ? p : entry_count) + 1;
                    if (grown > DEPTH)
                        res.status = ST_FULL;
                    else
                    begin
                        // Past the count the gap is zero filled; below it the
                        // tail moves up one slot.
                        if (p >= entry_count)
                            for (int i = entry_count; i < p; i++)
                                entries[i] = '0;
                        else
                            for (int i = entry_count; i > p; i--)
                                entries[i] = entries[i-1];
                        entries[p]  = val[WIDTH-1:0];
                        entry_count = grown;
                    end
                end
                CMD_REMOVE:
                    if (p >= entry_count)
                        res.status = ST_MISS;
                    else
                    begin
                        for (int i = p; i + 1 < entry_count; i++)
                            entries[i] = entries[i+1];
                        entry_count--;
                    end
                CMD_FIND:
                begin
                    for (int i = 0; i < entry_count && !hit; i++)
                        if (entries[i] == val[WIDTH-1:0])
                        begin
                            hit = 1'b1;
                            res.found_index = POS_W'(i);
                        end
                    if (!hit)
                        res.status = ST_MISS;
                end
                CMD_READ:
                    if (p >= entry_count)
                        res.status = ST_MISS;
                    else
                        res.value_out = VALUE_W'(entries[p]);
                CMD_CLEAR:
                    entry_count = 0;
                default:
                    ;
            endcase
            res.count_out = COUNT_W'(entry_count);
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [M_W-1:0] word);
            list_result_t got;
            list_result_t want;
            got.status      = word[1:0];
            got.value_out   = word[33:2];
            got.found_index = word[39:34];
            got.count_out   = word[40 +: COUNT_W];
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %h", $time, got);
                error_count++;
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                error_count++;
            end
            if (got.value_out !== want.value_out)
            begin
                $display("%0t: value_out expected %h actual %h",
                         $time, want.value_out, got.value_out);
                error_count++;
            end
            if (got.found_index !== want.found_index)
            begin
                $display("%0t: found_index expected %0d actual %0d",
                         $time, want.found_index, got.found_index);
                error_count++;
            end
            if (got.count_out !== want.count_out)
            begin
                $display("%0t: count_out expected %0d actual %0d",
                         $time, want.count_out, got.count_out);
                error_count++;
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    // s_tdata, from bit 0 up: command[3], position[6], value_in[32], zero pad.
    logic [47:0]     s_tdata;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    // m_tdata, from bit 0 up: status[2], value_out[32], found_index[6],
    // count_out[7], zero pad.
    logic [M_W-1:0]  m_tdata;

    list_scoreboard  sb = new();

    // Percentages of cycles in which the sender idles or the receiver stalls.
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              quiet_cycles   = 0;

    ordered_list_engine_top #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver decides its ready for the next edge at each falling edge,
    // so it never changes in the same step as the block's outputs.
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Monitor: at each rising edge both stream sides are sampled before the
    // block's own updates land, so every transaction is seen exactly once.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_command(s_tdata[2:0], s_tdata[8:3], s_tdata[40:9]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: a run of cycles with no transaction on either side means the
    // block has hung.
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // Presents one command and holds it until the block takes it. Random idle
    // cycles go in front, with noise on the data bus while valid is low.
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic [POS_W-1:0] pos,
                                input logic [VALUE_W-1:0] val);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 48'({$urandom, $urandom});
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, val, pos, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Lowers valid and holds off until every queued result has come back.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Values lean toward the extremes and a small pool, so that finds hit and
    // duplicates appear in the list.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 7);
            1:       return $urandom_range(0, 1) ? '1 : '0;
            default: return $urandom;
        endcase
    endfunction

    // One random command, mostly well formed against the current list so that
    // it fills up, shifts and empties again; the rest lands out of range.
    task automatic send_random_command();
        int                 roll;
        int                 cnt;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
        roll = $urandom_range(0, 99);
        cnt  = sb.entry_count;
        pos  = POS_W'($urandom);
        val  = pick_value();
        if (roll < 22)
            send_command(CMD_PUSH, pos, val);
        else if (roll < 36)
            send_command(CMD_POP, pos, val);
        else if (roll < 54)
        begin
            if (cnt < DEPTH && $urandom_range(0, 9) < 7)
                pos = POS_W'($urandom_range(0, cnt));
            send_command(CMD_INSERT, pos, val);
        end
        else if (roll < 66)
        begin
            if (cnt > 0 && $urandom_range(0, 9) < 8)
                pos = POS_W'($urandom_range(0, cnt - 1));
            send_command(CMD_REMOVE, pos, val);
        end
        else if (roll < 80)
        begin
            if (cnt > 0 && $urandom_range(0, 9) < 6)
                val = VALUE_W'(sb.entries[$urandom_range(0, cnt - 1)]);
            send_command(CMD_FIND, pos, val);
        end
        else if (roll < 94)
        begin
            if (cnt > 0 && $urandom_range(0, 9) < 8)
                pos = POS_W'($urandom_range(0, cnt - 1));
            send_command(CMD_READ, pos, val);
        end
        else if (roll < 97)
            send_command(CMD_CLEAR, pos, val);
        else
            send_command(CMD_UNUSED, pos, val);
    endtask

    initial
    begin
        int phase_idle  [4] = '{0, 65, 0, 32};
        int phase_stall [4] = '{0, 0, 65, 32};
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: every command, both ends of the fields, the empty and
        // full cases, a zero-filled gap and the ignored code.
        send_command(CMD_POP,    6'd0,  32'h0);
        send_command(CMD_READ,   6'd0,  32'h0);
        send_command(CMD_REMOVE, 6'd0,  32'h0);
        send_command(CMD_FIND,   6'd0,  32'h0);
        send_command(CMD_PUSH,   6'd0,  32'hFFFF_FFFF);
        send_command(CMD_PUSH,   6'd63, 32'h0);
        send_command(CMD_INSERT, 6'd0,  32'h1234_5678);
        send_command(CMD_INSERT, 6'd5,  32'hA5A5_A5A5);
        send_command(CMD_READ,   6'd3,  32'h0);
        send_command(CMD_READ,   6'd5,  32'h0);
        send_command(CMD_READ,   6'd6,  32'h0);
        send_command(CMD_FIND,   6'd0,  32'h0);
        send_command(CMD_FIND,   6'd0,  32'hDEAD_BEEF);
        send_command(CMD_REMOVE, 6'd0,  32'h0);
        send_command(CMD_REMOVE, 6'd10, 32'h0);
        send_command(CMD_POP,    6'd0,  32'h0);
        send_command(CMD_UNUSED, 6'd63, 32'hFFFF_FFFF);
        send_command(CMD_CLEAR,  6'd0,  32'h0);
        // Inserting at the last slot of an empty list fills it in one step.
        send_command(CMD_INSERT, 6'd63, 32'h5A5A_5A5A);
        send_command(CMD_PUSH,   6'd0,  32'h1);
        send_command(CMD_INSERT, 6'd0,  32'h2);
        send_command(CMD_READ,   6'd63, 32'h0);
        send_command(CMD_REMOVE, 6'd63, 32'h0);
        send_command(CMD_PUSH,   6'd0,  32'h1);
        send_command(CMD_CLEAR,  6'd0,  32'h0);
        drain_results();

        // Random part in four idling phases. Some stretches of each phase run
        // without any idling, and each phase ends with a full drain.
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int chunk = 0; chunk < 19; chunk++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                else
                begin
                    send_idle_pct  = phase_idle[ph];
                    recv_stall_pct = phase_stall[ph];
                end
                repeat (25) send_random_command();
            end
            drain_results();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        if (sb.error_count == 0 && sb.expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
